@@ rtl/i2d_pkg.sv @@
// Shared types and constants for the integer to decimal ASCII converter.
package i2d_pkg;

    localparam int DATA_WIDTH = 32;
    // Decimal digits of the largest magnitude, 2^(DATA_WIDTH-1).
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

    // Reciprocal of ten, scaled by 2^35: exact quotient for every 32-bit magnitude.
    localparam logic [DATA_WIDTH-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int                    RECIP_SHFT = 35;
    localparam int                    PROD_W     = 2 * DATA_WIDTH;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic                  negative;
        logic [DATA_WIDTH-1:0] mag;
    } i2d_item_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic      valid;
        i2d_item_t item;
    } i2d_head_t;

endpackage

@@ rtl/i2d_front.sv @@
// Front end: accept a request, split it into sign and unsigned magnitude.
module i2d_front import i2d_pkg::*;
(
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic                  full,
    output logic                  busy,
    output logic                  push,
    output i2d_item_t             item
);

    logic negative;

    assign negative = value[DATA_WIDTH-1];
    assign busy     = full;
    assign push     = start && !full;

    // Two's complement negate; the most negative value lands on 2^(N-1) unsigned.
    always_comb
    begin
        item.negative = negative;
        item.mag      = negative ? (~value + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : value;
    end

endmodule

@@ rtl/i2d_queue.sv @@
// Two-entry queue between the front end and the conversion back end.
module i2d_queue import i2d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  i2d_item_t push_item,
    input  logic      pop,
    output logic      full,
    output i2d_head_t head
);

    i2d_item_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/i2d_back.sv @@
// Back end: peel digits off by reciprocal multiply, then emit them most significant first.
module i2d_back import i2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  i2d_head_t  head,
    output logic       pop,
    output logic       strobe,
    output logic [7:0] character,
    output logic       last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_SIGN  = 4'b0100,
        S_DIGIT = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic [DATA_WIDTH-1:0] mag_next;
    logic [DIG_CNT_W-1:0]  cnt_reg;
    logic [DIG_CNT_W-1:0]  cnt_next;
    logic [3:0]            digit_reg [MAX_DIGITS];
    logic                  strobe_reg;
    logic                  strobe_next;
    logic [7:0]            char_reg;
    logic [7:0]            char_next;
    logic                  last_reg;
    logic                  last_next;

    logic [PROD_W-1:0]     prod;
    logic [DATA_WIDTH-1:0] quot;
    logic [DATA_WIDTH-1:0] rem;
    logic [DIG_CNT_W-1:0]  top_cnt;
    logic [DIG_IDX_W-1:0]  top_idx;
    logic                  dig_wr;

    // quot = floor(mag / 10); rem is the low digit.
    assign prod    = {{DATA_WIDTH{1'b0}}, mag_reg} * {{DATA_WIDTH{1'b0}}, RECIP_TEN};
    assign quot    = {{(DATA_WIDTH-PROD_W+RECIP_SHFT){1'b0}}, prod[PROD_W-1:RECIP_SHFT]};
    assign rem     = mag_reg - {quot[DATA_WIDTH-4:0], 3'b000} - {quot[DATA_WIDTH-2:0], 1'b0};
    assign top_cnt = cnt_reg - {{(DIG_CNT_W-1){1'b0}}, 1'b1};
    assign top_idx = top_cnt[DIG_IDX_W-1:0];
    assign dig_wr  = (state_reg == S_CONV);

    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    neg_next   = head.item.negative;
                    mag_next   = head.item.mag;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                mag_next = quot;
                cnt_next = cnt_reg + {{(DIG_CNT_W-1){1'b0}}, 1'b1};
                if (quot == '0)
                begin
                    state_next = neg_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                state_next  = S_DIGIT;
            end
            S_DIGIT:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_ZERO + {4'b0000, digit_reg[top_idx]};
                last_next   = (top_cnt == '0);
                cnt_next    = top_cnt;
                if (top_cnt == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        char_reg <= char_next;
        // Hold digits least significant first; emission walks back down.
        if (dig_wr)
        begin
            digit_reg[cnt_reg[DIG_IDX_W-1:0]] <= rem[3:0];
        end
    end

endmodule

@@ rtl/int_to_decimal_ascii.sv @@
// Top level of the signed integer to decimal ASCII converter.
//
//  channel   direction  handshake                 payload
//  request   in         start high, busy low      value[31:0] (signed)
//  result    out        strobe, one cycle each    character[7:0], last
//
// A request is converted with one reciprocal multiply per digit on the single
// multiplier, and its digits then leave on the result port most significant first,
// after a minus sign for a negative value.
// A two-entry queue takes requests while the back end works; busy rises when it fills.
// Reset is asynchronous and clears the queue and the back end's control state.
// The receiver cannot stall: every strobe is one result taken at that edge.
module int_to_decimal_ascii import i2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  busy,
    output logic                  strobe,
    output logic [7:0]            character,
    output logic                  last
);

    logic      full;
    logic      push;
    logic      pop;
    i2d_item_t item;
    i2d_head_t head;

    i2d_front u_front (
        .start (start),
        .value (value),
        .full  (full),
        .busy  (busy),
        .push  (push),
        .item  (item)
    );

    i2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (item),
        .pop       (pop),
        .full      (full),
        .head      (head)
    );

    i2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    // Only a minus sign or a decimal digit leaves the block.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (character == CHAR_MINUS ||
                    (character >= CHAR_ZERO && character <= CHAR_NINE)))
        else $error("result character out of range");

    // A minus sign is never the end of a string and is followed by a digit.
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && character == CHAR_MINUS) |=>
            (strobe && character != CHAR_MINUS))
        else $error("minus sign not followed by a digit");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && character == CHAR_MINUS) |-> !last)
        else $error("minus sign flagged last");

    // The back end pops only a queue that holds a request.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule
